### sv/ostb_pkg.sv
// Shared types and constants of the ordered soft timer bank.
package ostb_pkg;

  // Operation codes carried in tuser.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Field widths of the stream words.
  localparam int OP_W        = 2;
  localparam int SLOT_ID_W   = 3;
  localparam int LENGTH_W    = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // At most this many expiries are reported per tick.
  localparam int MAX_RESULTS = 8;

  // Flags produced by the shared compare unit.
  typedef struct packed {
    logic gt_one;
    logic gt_key;
  } cmp_flags_t;

endpackage

### sv/ostb_cmp_unit.sv
// Shared compare and decrement unit for timer counts.
module ostb_cmp_unit #(
  parameter int TICK_BITS = 32
) (
  input  logic [TICK_BITS-1:0] value_i,
  input  logic [TICK_BITS-1:0] key_i,
  output logic [TICK_BITS-1:0] dec_o,
  output ostb_pkg::cmp_flags_t flags_o
);

  assign dec_o          = value_i - TICK_BITS'(1);
  assign flags_o.gt_one = (value_i > TICK_BITS'(1));
  assign flags_o.gt_key = (value_i > key_i);

endmodule

### sv/ordered_soft_timer_bank.sv
// Top level of the ordered soft timer bank: list sequencer and slot storage.
// Add: an active slot is first unlinked by a scan of the list, then its record is
// written and the timer is inserted from the tail. Remove: clears the active flag and runs the unlink scan.
// Tick: every listed timer is decremented or moved to the expiry list, expiries are
// reported, and re-armed timers are inserted again; all steps share the order memory.
// One word at a time: s_axis_tready_o is high only while the sequencer is idle.
// Reset clears the list, the active flags and the output valid flag at once.
module ordered_soft_timer_bank #(
  parameter int SLOTS     = 8,
  parameter int TICK_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // slot_id[2:0], length[34:3], repeat_req[35], zero fill above
  input  logic [ostb_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // op[1:0]
  input  logic [ostb_pkg::OP_W-1:0]          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // expired_slot[2:0], zero fill above
  output logic [ostb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int IdW    = ostb_pkg::SLOT_ID_W;
  localparam int LenW   = ostb_pkg::LENGTH_W;
  localparam int MaxOut = (SLOTS < ostb_pkg::MAX_RESULTS) ? SLOTS : ostb_pkg::MAX_RESULTS;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_UNL_RD  = 5'd1;
  localparam logic [4:0] S_UNL_CHK = 5'd2;
  localparam logic [4:0] S_ADD_WR  = 5'd3;
  localparam logic [4:0] S_INS_BEG = 5'd4;
  localparam logic [4:0] S_INS_TOP = 5'd5;
  localparam logic [4:0] S_INS_ORD = 5'd6;
  localparam logic [4:0] S_INS_CMP = 5'd7;
  localparam logic [4:0] S_INS_PUT = 5'd8;
  localparam logic [4:0] S_TK_ORD  = 5'd9;
  localparam logic [4:0] S_TK_REC  = 5'd10;
  localparam logic [4:0] S_TK_UPD  = 5'd11;
  localparam logic [4:0] S_EM_RD   = 5'd12;
  localparam logic [4:0] S_EM_OUT  = 5'd13;
  localparam logic [4:0] S_RI_RD   = 5'd14;
  localparam logic [4:0] S_RI_REC  = 5'd15;
  localparam logic [4:0] S_RI_CHK  = 5'd16;

  logic [4:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        w_q, w_d;
  logic [CW-1:0]        nexp_q, nexp_d;
  logic [CW-1:0]        k_q, k_d;
  logic                 found_q, found_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [TICK_BITS-1:0] key_q, key_d;
  logic [1:0]           op_q, op_d;
  logic [TICK_BITS-1:0] len_q, len_d;
  logic                 rep_q, rep_d;
  logic [SLOTS-1:0]     active_q, active_d;
  logic                 m_valid_q, m_valid_d;
  logic [IdW-1:0]       m_slot_q, m_slot_d;
  logic                 m_last_q, m_last_d;

  // Order list, slot records and expiry list, each with one write and one read port.
  logic [SW-1:0]        ord_mem [SLOTS];
  logic [TICK_BITS-1:0] rem_mem [SLOTS];
  logic [TICK_BITS-1:0] rld_mem [SLOTS];
  logic                 rep_mem [SLOTS];
  logic [SW-1:0]        exp_mem [SLOTS];

  logic                 ord_we, ord_re;
  logic [SW-1:0]        ord_wa, ord_wd, ord_ra, ord_rd_q;
  logic                 rem_we, cfg_we, rec_re;
  logic [SW-1:0]        rec_wa, rec_ra;
  logic [TICK_BITS-1:0] rem_wd;
  logic [TICK_BITS-1:0] rem_rd_q, rld_rd_q;
  logic                 rep_rd_q;
  logic                 exp_we, exp_re;
  logic [SW-1:0]        exp_wa, exp_wd, exp_ra, exp_rd_q;

  logic [TICK_BITS-1:0] dec_val;
  ostb_pkg::cmp_flags_t flags;

  logic                 in_fire;
  logic [IdW-1:0]       in_sid;
  logic                 sid_ok;
  logic [CW-1:0]        n_out;
  logic [CW-1:0]        w_next, nexp_next;

  ostb_cmp_unit #(
    .TICK_BITS(TICK_BITS)
  ) u_cmp (
    .value_i(rem_rd_q),
    .key_i  (key_q),
    .dec_o  (dec_val),
    .flags_o(flags)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_sid          = s_axis_tdata_i[IdW-1:0];
  assign sid_ok          = (32'(in_sid) < SLOTS);
  assign n_out           = (nexp_q > CW'(MaxOut)) ? CW'(MaxOut) : nexp_q;
  assign w_next          = flags.gt_one ? (w_q + CW'(1)) : w_q;
  assign nexp_next       = flags.gt_one ? nexp_q : (nexp_q + CW'(1));

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(ostb_pkg::OUT_TDATA_W - IdW){1'b0}}, m_slot_q};
  assign m_axis_tlast_o  = m_last_q;

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    if (ord_re) begin
      ord_rd_q <= ord_mem[ord_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[rec_wa] <= rem_wd;
    end
    if (cfg_we) begin
      rld_mem[rec_wa] <= len_q;
      rep_mem[rec_wa] <= rep_q;
    end
    if (rec_re) begin
      rem_rd_q <= rem_mem[rec_ra];
      rld_rd_q <= rld_mem[rec_ra];
      rep_rd_q <= rep_mem[rec_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      exp_mem[exp_wa] <= exp_wd;
    end
    if (exp_re) begin
      exp_rd_q <= exp_mem[exp_ra];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    w_d       = w_q;
    nexp_d    = nexp_q;
    k_d       = k_q;
    found_d   = found_q;
    slot_d    = slot_q;
    key_d     = key_q;
    op_d      = op_q;
    len_d     = len_q;
    rep_d     = rep_q;
    active_d  = active_q;
    m_valid_d = m_valid_q;
    m_slot_d  = m_slot_q;
    m_last_d  = m_last_q;
    ord_we    = 1'b0;
    ord_wa    = idx_q[SW-1:0];
    ord_wd    = ord_rd_q;
    ord_re    = 1'b0;
    ord_ra    = idx_q[SW-1:0];
    rem_we    = 1'b0;
    cfg_we    = 1'b0;
    rec_wa    = slot_q;
    rem_wd    = len_q;
    rec_re    = 1'b0;
    rec_ra    = ord_rd_q;
    exp_we    = 1'b0;
    exp_wa    = nexp_q[SW-1:0];
    exp_wd    = ord_rd_q;
    exp_re    = 1'b0;
    exp_ra    = k_q[SW-1:0];

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = s_axis_tuser_i;
          len_d   = TICK_BITS'(s_axis_tdata_i[IdW +: LenW]);
          rep_d   = s_axis_tdata_i[IdW + LenW];
          slot_d  = SW'(in_sid);
          idx_d   = '0;
          w_d     = '0;
          nexp_d  = '0;
          found_d = 1'b0;
          unique case (s_axis_tuser_i)
            ostb_pkg::OP_ADD: begin
              if (sid_ok) begin
                if (active_q[SW'(in_sid)] && (cnt_q != '0)) begin
                  state_d = S_UNL_RD;
                end else begin
                  state_d = S_ADD_WR;
                end
              end
            end
            ostb_pkg::OP_REMOVE: begin
              if (sid_ok) begin
                active_d[SW'(in_sid)] = 1'b0;
                if (active_q[SW'(in_sid)] && (cnt_q != '0)) begin
                  state_d = S_UNL_RD;
                end
              end
            end
            ostb_pkg::OP_TICK: begin
              if (cnt_q != '0) begin
                state_d = S_TK_ORD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_UNL_RD: begin
        ord_re  = 1'b1;
        state_d = S_UNL_CHK;
      end

      S_UNL_CHK: begin
        // Once the slot is found, every later entry moves down by one place.
        if (found_q) begin
          ord_we = 1'b1;
          ord_wa = SW'(idx_q - CW'(1));
        end
        found_d = found_q || (ord_rd_q == slot_q);
        idx_d   = idx_q + CW'(1);
        if ((idx_q + CW'(1)) == cnt_q) begin
          if (found_d) begin
            cnt_d = cnt_q - CW'(1);
          end
          state_d = (op_q == ostb_pkg::OP_ADD) ? S_ADD_WR : S_IDLE;
        end else begin
          state_d = S_UNL_RD;
        end
      end

      S_ADD_WR: begin
        rem_we            = 1'b1;
        cfg_we            = 1'b1;
        active_d[slot_q]  = 1'b1;
        key_d             = len_q;
        state_d           = S_INS_BEG;
      end

      S_INS_BEG: begin
        if (cnt_q >= CW'(SLOTS)) begin
          state_d = (op_q == ostb_pkg::OP_TICK) ? S_RI_RD : S_IDLE;
        end else begin
          idx_d   = cnt_q;
          state_d = S_INS_TOP;
        end
      end

      // The list stays sorted, so the insert walks back from the tail.
      S_INS_TOP: begin
        if (idx_q == '0) begin
          state_d = S_INS_PUT;
        end else begin
          ord_re  = 1'b1;
          ord_ra  = SW'(idx_q - CW'(1));
          state_d = S_INS_ORD;
        end
      end

      S_INS_ORD: begin
        rec_re  = 1'b1;
        rec_ra  = ord_rd_q;
        state_d = S_INS_CMP;
      end

      S_INS_CMP: begin
        if (flags.gt_key) begin
          ord_we  = 1'b1;
          idx_d   = idx_q - CW'(1);
          state_d = S_INS_TOP;
        end else begin
          state_d = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        ord_we  = 1'b1;
        ord_wd  = slot_q;
        cnt_d   = cnt_q + CW'(1);
        state_d = (op_q == ostb_pkg::OP_TICK) ? S_RI_RD : S_IDLE;
      end

      S_TK_ORD: begin
        ord_re  = 1'b1;
        state_d = S_TK_REC;
      end

      S_TK_REC: begin
        rec_re  = 1'b1;
        rec_ra  = ord_rd_q;
        state_d = S_TK_UPD;
      end

      // Survivors are compacted in place; expired slots go to the expiry list.
      S_TK_UPD: begin
        if (flags.gt_one) begin
          rem_we = 1'b1;
          rec_wa = ord_rd_q;
          rem_wd = dec_val;
          ord_we = 1'b1;
          ord_wa = w_q[SW-1:0];
        end else begin
          active_d[ord_rd_q] = 1'b0;
          exp_we             = 1'b1;
        end
        w_d    = w_next;
        nexp_d = nexp_next;
        idx_d  = idx_q + CW'(1);
        if ((idx_q + CW'(1)) == cnt_q) begin
          cnt_d   = w_next;
          k_d     = '0;
          state_d = (nexp_next == '0) ? S_IDLE : S_EM_RD;
        end else begin
          state_d = S_TK_ORD;
        end
      end

      S_EM_RD: begin
        exp_re  = 1'b1;
        state_d = S_EM_OUT;
      end

      S_EM_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_slot_d  = IdW'(exp_rd_q);
          m_last_d  = ((k_q + CW'(1)) == n_out);
          if ((k_q + CW'(1)) == n_out) begin
            k_d     = '0;
            state_d = S_RI_RD;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = S_EM_RD;
          end
        end
      end

      S_RI_RD: begin
        if (k_q == nexp_q) begin
          state_d = S_IDLE;
        end else begin
          exp_re  = 1'b1;
          state_d = S_RI_REC;
        end
      end

      S_RI_REC: begin
        slot_d  = exp_rd_q;
        rec_re  = 1'b1;
        rec_ra  = exp_rd_q;
        state_d = S_RI_CHK;
      end

      S_RI_CHK: begin
        k_d = k_q + CW'(1);
        if (rep_rd_q) begin
          rem_we           = 1'b1;
          rem_wd           = rld_rd_q;
          active_d[slot_q] = 1'b1;
          key_d            = rld_rd_q;
          state_d          = S_INS_BEG;
        end else begin
          state_d = S_RI_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      w_q       <= '0;
      nexp_q    <= '0;
      k_q       <= '0;
      found_q   <= 1'b0;
      active_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      w_q       <= w_d;
      nexp_q    <= nexp_d;
      k_q       <= k_d;
      found_q   <= found_d;
      active_q  <= active_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    key_q    <= key_d;
    op_q     <= op_d;
    len_q    <= len_d;
    rep_q    <= rep_d;
    m_slot_q <= m_slot_d;
    m_last_q <= m_last_d;
  end

endmodule
